[rtl/shared_buffer_multi_queue_top_assert.svh]
// Assertion macros shared by the shared-buffer multi-queue RTL.
// Expects clk and arst_n in the scope of the module that uses them.
`ifndef SHARED_BUFFER_MULTI_QUEUE_TOP_ASSERT_SVH
`define SHARED_BUFFER_MULTI_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SBMQ_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define SBMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/sbmq_pkg.sv]
// Types and constants for the shared-buffer multi-queue block.
// Used by sbmq_front, sbmq_back and shared_buffer_multi_queue_top.
package sbmq_pkg;

	localparam int QSEL_W    = 3;
	localparam int VALUE_W   = 32;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 32;

	localparam logic KIND_ENQ = 1'b0;
	localparam logic KIND_DEQ = 1'b1;

	typedef enum logic [1:0] {
		OP_ENQ,
		OP_DEQ,
		OP_REJECT
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic [QSEL_W-1:0]   qsel;
		logic [VALUE_W-1:0]  value;
	} cmd_t;

	typedef struct packed {
		logic                ok;
		logic [VALUE_W-1:0]  value;
	} res_t;

endpackage

[rtl/shared_buffer_multi_queue_top.sv]
// Shared-buffer multi-queue: several FIFO queues held as linked lists in one data store.
// Instantiates sbmq_front and sbmq_back; depends on sbmq_pkg.
//
// Usage: the input stream carries one command per word. tuser is the kind (0 enqueue
// value_in, 1 dequeue), tdata holds queue_sel and value_in. Every command yields exactly
// one output word: tuser is ok, tdata the dequeued value (zero unless a dequeue found data).
// An enqueue into a full store, a dequeue of an empty queue and a queue number at or above
// NUM_QUEUES return ok = 0 and change nothing.
// The front end queues up to two decoded commands, so input is taken while the back end
// works or while a result waits in the output register. The back end sequencer runs one
// command at a time on the two-port link store: an accepted enqueue passes S_RD and S_WR2,
// an accepted dequeue S_RD and S_DQ, a full or empty refusal S_RD only, and an invalid
// queue is answered from idle; each result is held in the output register.
// After reset all queues are empty and every slot is free; no clearing pass is needed, since
// a fill count stands in for the initial free-list links.
// When the receiver holds m_tready low, the result stays in the output register, the back end
// waits before its next command, and s_tready drops once two commands are queued.
module shared_buffer_multi_queue_top
	import sbmq_pkg::*;
#(
	parameter int NUM_QUEUES = 8,
	parameter int SLOTS      = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // [2:0] queue_sel, [34:3] value_in, rest zero
	input  logic                 s_tuser,   // [0] kind
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // [31:0] value_out
	output logic                 m_tuser    // [0] ok
);

	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;
	res_t res;

	sbmq_front #(
		.NUM_QUEUES(NUM_QUEUES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd)
	);

	sbmq_back #(
		.NUM_QUEUES(NUM_QUEUES),
		.SLOTS     (SLOTS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.res_valid(m_tvalid),
		.res_ready(m_tready),
		.res      (res)
	);

	assign m_tdata = res.value;
	assign m_tuser = res.ok;

endmodule

[rtl/sbmq_front.sv]
// Front end: accepts input words, decodes them into commands and queues them.
// Depends on sbmq_pkg.
module sbmq_front
	import sbmq_pkg::*;
#(
	parameter int NUM_QUEUES = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // [2:0] queue_sel, [34:3] value_in, rest zero
	input  logic                 s_tuser,   // [0] kind
	output logic                 cmd_valid,
	input  logic                 cmd_ready,
	output cmd_t                 cmd
);

	cmd_t              fifo_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;
	cmd_t              in_cmd;
	logic              push;
	logic              pop;

	// A queue number at or above the configured count is marked for refusal by the back end.
	always_comb begin
		in_cmd.qsel  = s_tdata[QSEL_W-1:0];
		in_cmd.value = s_tdata[QSEL_W +: VALUE_W];
		if (int'(in_cmd.qsel) >= NUM_QUEUES) begin
			in_cmd.op = OP_REJECT;
		end else if (s_tuser == KIND_DEQ) begin
			in_cmd.op = OP_DEQ;
		end else begin
			in_cmd.op = OP_ENQ;
		end
	end

	assign s_tready  = (count_q != 2'd2);
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = fifo_q[rd_ptr_q];
	assign push      = s_tvalid && s_tready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[rtl/sbmq_back.sv]
// Back end: runs queue commands against the shared data and link stores.
// Depends on sbmq_pkg and shared_buffer_multi_queue_top_assert.svh.
`include "shared_buffer_multi_queue_top_assert.svh"

module sbmq_back
	import sbmq_pkg::*;
#(
	parameter int NUM_QUEUES = 8,
	parameter int SLOTS      = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  cmd_t cmd,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int PW = $clog2(SLOTS + 1);
	localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam logic [PW-1:0] NULL_PTR = PW'(SLOTS);

	typedef enum logic [1:0] {
		S_IDLE,
		S_RD,
		S_DQ,
		S_WR2
	} state_t;

	state_t               state_q;
	op_t                  op_q;
	logic [QW-1:0]        qidx_q;
	logic [VALUE_W-1:0]   value_q;
	logic [PW-1:0]        slot_q;
	logic [PW-1:0]        free_head_q;
	logic [PW-1:0]        fresh_q;
	logic [NUM_QUEUES-1:0] qv_q;
	logic                 qv_rd_q;
	logic [PW-1:0]        link_addr_q;
	logic                 res_valid_q;
	logic                 res_ok_q;
	logic [VALUE_W-1:0]   res_value_q;

	logic [VALUE_W-1:0]   data_mem [SLOTS];
	logic [PW-1:0]        link_mem [SLOTS];
	logic [PW-1:0]        head_mem [NUM_QUEUES];
	logic [PW-1:0]        tail_mem [NUM_QUEUES];
	logic [VALUE_W-1:0]   data_rd_q;
	logic [PW-1:0]        link_rd_q;
	logic [PW-1:0]        head_rd_q;
	logic [PW-1:0]        tail_rd_q;

	logic                 start;
	logic [QW-1:0]        q_raddr;
	logic [PW-1:0]        link_rptr;
	logic [AW-1:0]        link_raddr;
	logic [PW-1:0]        head_eff;
	logic [PW-1:0]        tail_eff;
	logic [PW-1:0]        link_eff;
	logic                 link_we;
	logic [AW-1:0]        link_waddr;
	logic [PW-1:0]        link_wdata;
	logic                 head_we;
	logic [PW-1:0]        head_wdata;
	logic                 tail_we;
	logic [PW-1:0]        tail_wdata;
	logic                 data_we;

	function automatic logic [AW-1:0] to_addr(input logic [PW-1:0] p);
		to_addr = (p < NULL_PTR) ? p[AW-1:0] : '0;
	endfunction

	assign cmd_ready = (state_q == S_IDLE) && (!res_valid_q || res_ready);
	assign start     = cmd_valid && cmd_ready;
	assign res_valid = res_valid_q;
	assign res.ok    = res_ok_q;
	assign res.value = res_value_q;

	assign q_raddr   = (cmd.op == OP_REJECT) ? '0 : QW'(cmd.qsel);
	assign head_eff  = qv_rd_q ? head_rd_q : NULL_PTR;
	assign tail_eff  = qv_rd_q ? tail_rd_q : NULL_PTR;
	assign link_rptr = (state_q == S_IDLE) ? free_head_q : head_eff;
	assign link_raddr = to_addr(link_rptr);

	// Slots at or above the fill count were never linked; their link is taken
	// as the following slot (the last one's as null).
	assign link_eff = (link_addr_q >= fresh_q) ? link_addr_q + PW'(1) : link_rd_q;

	always_comb begin
		link_we    = 1'b0;
		link_waddr = '0;
		link_wdata = NULL_PTR;
		head_we    = 1'b0;
		head_wdata = NULL_PTR;
		tail_we    = 1'b0;
		tail_wdata = NULL_PTR;
		data_we    = 1'b0;
		unique case (state_q)
			S_RD: begin
				if (op_q == OP_ENQ && free_head_q != NULL_PTR) begin
					data_we    = 1'b1;
					tail_we    = 1'b1;
					tail_wdata = free_head_q;
					if (head_eff == NULL_PTR) begin
						head_we    = 1'b1;
						head_wdata = free_head_q;
					end else begin
						link_we    = 1'b1;
						link_waddr = to_addr(tail_eff);
						link_wdata = free_head_q;
					end
				end
			end
			S_DQ: begin
				head_we    = 1'b1;
				head_wdata = link_eff;
				tail_we    = (link_eff == NULL_PTR);
				link_we    = 1'b1;
				link_waddr = to_addr(slot_q);
				link_wdata = free_head_q;
			end
			S_WR2: begin
				link_we    = 1'b1;
				link_waddr = to_addr(slot_q);
				link_wdata = NULL_PTR;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_waddr] <= link_wdata;
		end
		link_rd_q <= link_mem[link_raddr];
	end

	always_ff @(posedge clk) begin
		if (data_we) begin
			data_mem[to_addr(free_head_q)] <= value_q;
		end
		data_rd_q <= data_mem[to_addr(head_eff)];
	end

	always_ff @(posedge clk) begin
		if (head_we) begin
			head_mem[qidx_q] <= head_wdata;
		end
		if (tail_we) begin
			tail_mem[qidx_q] <= tail_wdata;
		end
		head_rd_q <= head_mem[q_raddr];
		tail_rd_q <= tail_mem[q_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_REJECT;
			qidx_q      <= '0;
			value_q     <= '0;
			slot_q      <= NULL_PTR;
			free_head_q <= '0;
			fresh_q     <= '0;
			qv_q        <= '0;
			qv_rd_q     <= 1'b0;
			link_addr_q <= '0;
			res_valid_q <= 1'b0;
			res_ok_q    <= 1'b0;
			res_value_q <= '0;
		end else begin
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q        <= cmd.op;
						qidx_q      <= q_raddr;
						value_q     <= cmd.value;
						qv_rd_q     <= qv_q[q_raddr];
						link_addr_q <= free_head_q;
						if (cmd.op == OP_REJECT) begin
							res_valid_q <= 1'b1;
							res_ok_q    <= 1'b0;
							res_value_q <= '0;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					if (op_q == OP_ENQ) begin
						if (free_head_q == NULL_PTR) begin
							res_valid_q <= 1'b1;
							res_ok_q    <= 1'b0;
							res_value_q <= '0;
							state_q     <= S_IDLE;
						end else begin
							slot_q       <= free_head_q;
							free_head_q  <= link_eff;
							qv_q[qidx_q] <= 1'b1;
							if (free_head_q == fresh_q) begin
								fresh_q <= fresh_q + PW'(1);
							end
							state_q <= S_WR2;
						end
					end else if (head_eff == NULL_PTR) begin
						res_valid_q <= 1'b1;
						res_ok_q    <= 1'b0;
						res_value_q <= '0;
						state_q     <= S_IDLE;
					end else begin
						slot_q      <= head_eff;
						link_addr_q <= head_eff;
						state_q     <= S_DQ;
					end
				end
				S_DQ: begin
					free_head_q <= slot_q;
					res_valid_q <= 1'b1;
					res_ok_q    <= 1'b1;
					res_value_q <= data_rd_q;
					state_q     <= S_IDLE;
				end
				S_WR2: begin
					res_valid_q <= 1'b1;
					res_ok_q    <= 1'b1;
					res_value_q <= '0;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`SBMQ_ASSERT_IMPL(a_refused_zero, res_valid_q && !res_ok_q, res_value_q == '0, "refused word carries data")
	`SBMQ_ASSERT_IMPL(a_free_head_range, 1'b1, free_head_q <= NULL_PTR, "free head out of range")
	`SBMQ_ASSERT_IMPL(a_fresh_range, 1'b1, fresh_q <= NULL_PTR, "fill count out of range")
	`SBMQ_ASSERT_IMPL(a_busy_no_result, state_q != S_IDLE, !res_valid_q, "result pending during command")
	`SBMQ_ASSERT_NEXT(a_enq_done, state_q == S_WR2, state_q == S_IDLE && res_valid_q && res_ok_q, "enqueue did not finish")

endmodule

[verif/tb_top.sv]
// Self-checking testbench for shared_buffer_multi_queue_top: enqueue and dequeue words
// are checked against a linked-list model of the shared store kept in this file.
// Depends on sbmq_pkg and the RTL of the block; reads no files.
`timescale 1ns / 1ps

module tb_top
	import sbmq_pkg::*;
();

	localparam int NUM_Q       = 8;
	localparam int NUM_SLOTS   = 64;
	localparam int RAND_WORDS  = 800;
	localparam int BLOCK_LEN   = 40;
	localparam int IDLE_PCT    = 24;
	localparam int HOLD_AFTER  = 300;
	localparam int HOLD_CYCLES = 150;
	localparam int DRAIN       = 16;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [6:0] NULL_SLOT = 7'(NUM_SLOTS);

	typedef struct {
		logic              kind;
		logic [QSEL_W-1:0] qsel;
		logic [VALUE_W-1:0] value;
		int                reps;
		bit                known;
		res_t              want;
	} vec_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic                 s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tuser;

	// Model of the shared store.
	logic [VALUE_W-1:0] data_mem [NUM_SLOTS];
	logic [6:0]         link_mem [NUM_SLOTS];
	logic [6:0]         q_head   [NUM_Q];
	logic [6:0]         q_tail   [NUM_Q];
	logic [6:0]         free_ptr;

	res_t pending_results [$];
	int   words_accepted = 0;
	int   results_seen = 0;
	int   fail_count = 0;
	int   shown = 0;
	int   cycle_count = 0;
	int   n_enq = 0, n_full = 0, n_deq = 0, n_empty = 0;
	bit   calm = 1'b0;

	// Directed words. Rows with a repeat count add the repeat index to the value.
	vec_row_t directed_rows [25] = '{
		'{KIND_DEQ, 3'd0, 32'h0000_0000,  1, 1'b1, {1'b0, 32'h0000_0000}},
		'{KIND_DEQ, 3'd7, 32'hFFFF_FFFF,  1, 1'b1, {1'b0, 32'h0000_0000}},
		'{KIND_ENQ, 3'd0, 32'h8000_0000,  1, 1'b1, {1'b1, 32'h0000_0000}},
		'{KIND_ENQ, 3'd7, 32'h7FFF_FFFF,  1, 1'b1, {1'b1, 32'h0000_0000}},
		'{KIND_ENQ, 3'd0, 32'hFFFF_FFFF,  1, 1'b1, {1'b1, 32'h0000_0000}},
		'{KIND_ENQ, 3'd0, 32'h0000_0000,  1, 1'b1, {1'b1, 32'h0000_0000}},
		'{KIND_DEQ, 3'd0, 32'h0000_0000,  1, 1'b1, {1'b1, 32'h8000_0000}},
		'{KIND_DEQ, 3'd7, 32'h0000_0000,  1, 1'b1, {1'b1, 32'h7FFF_FFFF}},
		'{KIND_ENQ, 3'd7, 32'h5555_5555,  1, 1'b1, {1'b1, 32'h0000_0000}},
		'{KIND_ENQ, 3'd7, 32'hAAAA_AAAA,  1, 1'b1, {1'b1, 32'h0000_0000}},
		'{KIND_DEQ, 3'd7, 32'h0000_0000,  1, 1'b1, {1'b1, 32'h5555_5555}},
		'{KIND_DEQ, 3'd7, 32'h0000_0000,  1, 1'b1, {1'b1, 32'hAAAA_AAAA}},
		'{KIND_DEQ, 3'd7, 32'h0000_0000,  1, 1'b1, {1'b0, 32'h0000_0000}},
		'{KIND_DEQ, 3'd0, 32'h0000_0000,  1, 1'b0, {1'b0, 32'h0000_0000}},
		'{KIND_DEQ, 3'd0, 32'h0000_0000,  1, 1'b0, {1'b0, 32'h0000_0000}},
		'{KIND_DEQ, 3'd0, 32'h0000_0000,  1, 1'b1, {1'b0, 32'h0000_0000}},
		'{KIND_ENQ, 3'd3, 32'h1234_0000, 64, 1'b1, {1'b1, 32'h0000_0000}},
		'{KIND_ENQ, 3'd5, 32'h0000_0001,  1, 1'b1, {1'b0, 32'h0000_0000}},
		'{KIND_DEQ, 3'd5, 32'h0000_0000,  1, 1'b1, {1'b0, 32'h0000_0000}},
		'{KIND_DEQ, 3'd3, 32'h0000_0000,  1, 1'b1, {1'b1, 32'h1234_0000}},
		'{KIND_ENQ, 3'd5, 32'hDEAD_BEEF,  1, 1'b1, {1'b1, 32'h0000_0000}},
		'{KIND_ENQ, 3'd1, 32'h0000_0001,  1, 1'b1, {1'b0, 32'h0000_0000}},
		'{KIND_DEQ, 3'd3, 32'h0000_0000, 63, 1'b0, {1'b0, 32'h0000_0000}},
		'{KIND_DEQ, 3'd5, 32'h0000_0000,  1, 1'b1, {1'b1, 32'hDEAD_BEEF}},
		'{KIND_DEQ, 3'd3, 32'h0000_0000,  1, 1'b1, {1'b0, 32'h0000_0000}}
	};

	shared_buffer_multi_queue_top #(
		.NUM_QUEUES(NUM_Q),
		.SLOTS     (NUM_SLOTS)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Applies one command to the model and returns the word the block should send back.
	function automatic res_t apply_queue_op(input logic kind, input logic [QSEL_W-1:0] qsel,
			input logic [VALUE_W-1:0] value);
		res_t       r;
		logic [6:0] slot;
		r = '0;
		if (int'(qsel) >= NUM_Q)
			return r;
		if (kind == KIND_ENQ) begin
			slot = free_ptr;
			if (slot < NULL_SLOT) begin
				free_ptr = link_mem[slot[5:0]];
				if (q_head[qsel] >= NULL_SLOT)
					q_head[qsel] = slot;
				else if (q_tail[qsel] < NULL_SLOT)
					link_mem[q_tail[qsel][5:0]] = slot;
				link_mem[slot[5:0]] = NULL_SLOT;
				q_tail[qsel] = slot;
				data_mem[slot[5:0]] = value;
				r.ok = 1'b1;
				n_enq++;
			end else begin
				n_full++;
			end
		end else begin
			slot = q_head[qsel];
			if (slot < NULL_SLOT) begin
				q_head[qsel] = link_mem[slot[5:0]];
				// Taking the last element empties the tail as well.
				if (q_head[qsel] >= NULL_SLOT) begin
					q_head[qsel] = NULL_SLOT;
					q_tail[qsel] = NULL_SLOT;
				end
				link_mem[slot[5:0]] = free_ptr;
				free_ptr = slot;
				r.ok = 1'b1;
				r.value = data_mem[slot[5:0]];
				n_deq++;
			end else begin
				n_empty++;
			end
		end
		return r;
	endfunction

	// Offers one word, waits for the handshake, then records what should come back.
	task automatic offer_word(input logic kind, input logic [QSEL_W-1:0] qsel,
			input logic [VALUE_W-1:0] value, input bit known, input res_t want);
		res_t r;
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {{(S_TDATA_W - VALUE_W - QSEL_W){1'b0}}, value, qsel};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		r = apply_queue_op(kind, qsel, value);
		if (known)
			r = want;
		pending_results.push_back(r);
		words_accepted++;
	endtask

	initial begin : stimulus
		int               enq_pct;
		bit               focused;
		logic [QSEL_W-1:0] qa, qb, qsel;
		logic             kind;
		int               start;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser  <= KIND_ENQ;
		s_tdata  <= '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			data_mem[i] = '0;
			link_mem[i] = 7'(i + 1);
		end
		link_mem[NUM_SLOTS-1] = NULL_SLOT;
		for (int q = 0; q < NUM_Q; q++) begin
			q_head[q] = NULL_SLOT;
			q_tail[q] = NULL_SLOT;
		end
		free_ptr = '0;
		enq_pct = 50;
		focused = 1'b0;
		qa = '0;
		qb = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			for (int r = 0; r < directed_rows[i].reps; r++)
				offer_word(directed_rows[i].kind, directed_rows[i].qsel,
					directed_rows[i].value + VALUE_W'(r), directed_rows[i].known,
					directed_rows[i].want);

		// Blocks switch at random between filling, draining and balanced traffic, sometimes
		// aimed at two queues only, so the store runs full and queues run dry.
		for (int i = 0; i < RAND_WORDS; i++) begin
			if (i % BLOCK_LEN == 0) begin
				case ($urandom_range(2))
					0: enq_pct = 15;
					1: enq_pct = 50;
					default: enq_pct = 85;
				endcase
				focused = 1'($urandom_range(1));
				qa = QSEL_W'($urandom_range(NUM_Q - 1));
				qb = QSEL_W'($urandom_range(NUM_Q - 1));
			end
			calm = (i >= 500 && i < 650);
			kind = ($urandom_range(99) < enq_pct) ? KIND_ENQ : KIND_DEQ;
			if (focused)
				qsel = $urandom_range(1) ? qa : qb;
			else
				qsel = QSEL_W'($urandom_range(NUM_Q - 1));
			// Most dequeues go to a queue that holds data.
			if (kind == KIND_DEQ && $urandom_range(99) < 85) begin
				start = $urandom_range(NUM_Q - 1);
				for (int k = 0; k < NUM_Q; k++)
					if (q_head[qsel] >= NULL_SLOT)
						qsel = QSEL_W'((start + k) % NUM_Q);
			end
			offer_word(kind, qsel, VALUE_W'($urandom), 1'b0, '0);
		end
		calm = 1'b0;
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("tb_top: %0d words: %0d enqueued, %0d refused on a full store", words_accepted,
			n_enq, n_full);
		$display("tb_top: %0d dequeued with data, %0d on an empty queue, %0d results checked",
			n_deq, n_empty, results_seen);
		if (fail_count == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: %0d failures", fail_count);
			$display("tb_top: done, errors");
		end
		$finish;
	end

	// Receiver: random stalls, one long hold-off to back the block up, and a calm stretch.
	initial begin : result_sink
		int  hold_left;
		bit  held;
		hold_left = 0;
		held = 1'b0;
		m_tready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (!held && words_accepted >= HOLD_AFTER) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (calm) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= IDLE_PCT);
			end
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				fail_count++;
				if (shown < 10)
					$display("tb_top: result word with nothing expected: ok %0b value %h",
						m_tuser, m_tdata);
				shown++;
			end else begin
				want = pending_results.pop_front();
				if (m_tuser !== want.ok || m_tdata !== want.value) begin
					fail_count++;
					if (shown < 10)
						$display("tb_top: result %0d: expected ok %0b value %h, got ok %0b value %h",
							results_seen, want.ok, want.value, m_tuser, m_tdata);
					shown++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top: timeout with %0d results outstanding", pending_results.size());
			$display("tb_top: done, errors");
			$finish;
		end
	end

endmodule
